>>> design/bba_pkg.sv
`default_nettype none

package bba_pkg;

    localparam int CMD_W      = 2;
    localparam int IDX_W      = 8;
    localparam int STATUS_W   = 2;
    localparam int DISK_W     = 9;
    localparam int START_W    = 8;
    localparam int COUNT_W    = 9;
    localparam int ROW_BITS   = 8;
    localparam int ROW_SHIFT  = 3;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX       = 9'd256;
    localparam logic [DISK_W-1:0]  DISK_BLOCKS_RST = 9'd256;
    localparam logic [START_W-1:0] DATA_START_RST  = 8'd8;

    typedef enum logic [CMD_W-1:0] {
        CMD_FORMAT = 2'd0,
        CMD_ALLOC  = 2'd1,
        CMD_FREE   = 2'd2,
        CMD_QUERY  = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK           = 2'd0,
        STS_NO_FREE      = 2'd1,
        STS_OUT_OF_RANGE = 2'd2
    } t_status;

    typedef enum logic {
        REG_DISK_BLOCKS = 1'b0,
        REG_DATA_START  = 1'b1
    } t_reg;

endpackage

`default_nettype wire

>>> design/bba_req_if.sv
`default_nettype none

interface bba_req_if import bba_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] cmd;
    logic [IDX_W-1:0] block_index;

    modport source (output valid, output cmd, output block_index, input ready);
    modport sink   (input valid, input cmd, input block_index, output ready);
endinterface

`default_nettype wire

>>> design/bba_rsp_if.sv
`default_nettype none

interface bba_rsp_if import bba_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    granted_block;
    logic [COUNT_W-1:0]  free_count;

    modport source (output valid, output status, output granted_block, output free_count,
                    input ready);
    modport sink   (input valid, input status, input granted_block, input free_count,
                    output ready);
endinterface

`default_nettype wire

>>> design/bba_ram.sv
`default_nettype none

module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> design/block_bitmap_allocator_unit.sv
// First-fit disk block allocator over a used/free bitmap held in a RAM of 8-bit rows
// (one bit per block, bit j of row r is block 8*r+j). Format rewrites every row, marking
// blocks below data_start used, and reloads the free count; allocate scans rows from the
// row of data_start upward, one row read per cycle through the single RAM read port, and
// marks the lowest free block below the disk size; free does a read-modify-write of one
// row. Every command returns one word carrying the status, the granted block (zero unless
// an allocate succeeds) and the free count. One command is in flight at a time, and the
// next is taken while the previous result word waits in the output register. After reset
// a clearing pass wipes the map and no command is taken meanwhile; configuration writes
// are taken at any time. Registers: disk_blocks at byte address 0, data_start at 4.
`default_nettype none

module block_bitmap_allocator_unit import bba_pkg::*; #(
    parameter int MAP_BLOCKS = 256
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    bba_req_if.sink                    i_req,
    bba_rsp_if.source                  o_rsp,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int ROWS = (MAP_BLOCKS + ROW_BITS - 1) / ROW_BITS;
    localparam int RAW  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int RCW  = RAW + 1;
    localparam int PW   = (RAW + 4 > 10) ? RAW + 4 : 10;

    localparam logic [PW-1:0]  MAP_PW   = PW'(MAP_BLOCKS);
    localparam logic [RCW-1:0] LAST_ROW = RCW'(ROWS - 1);
    localparam logic [RCW-1:0] ROWS_CNT = RCW'(ROWS);

    typedef enum logic [4:0] {
        S_SWEEP = 5'b00001,
        S_IDLE  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_FREE  = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    // configuration registers
    logic [DISK_W-1:0]  r_disk_blocks;
    logic [START_W-1:0] r_data_start;
    logic               cfg_wr;
    t_reg               cfg_reg;

    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_reg = t_reg'(paddr[2]);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disk_blocks <= DISK_BLOCKS_RST;
            r_data_start  <= DATA_START_RST;
        end else if (cfg_wr) begin
            unique case (cfg_reg)
                REG_DISK_BLOCKS: r_disk_blocks <= pwdata[DISK_W-1:0];
                REG_DATA_START:  r_data_start  <= pwdata[START_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_reg)
            REG_DISK_BLOCKS: prdata = APB_DATA_W'(r_disk_blocks);
            REG_DATA_START:  prdata = APB_DATA_W'(r_data_start);
            default:         prdata = '0;
        endcase
    end

    // sequencer state
    t_state               r_state,      n_state;
    logic [RCW-1:0]       r_row,        n_row;
    logic                 r_fmt,        n_fmt;
    logic [RAW-1:0]       r_chk_row,    n_chk_row;
    logic                 r_chk_vld,    n_chk_vld;
    logic [RAW-1:0]       r_frow,       n_frow;
    logic [ROW_SHIFT-1:0] r_fbit,       n_fbit;
    logic                 r_fin_disk,   n_fin_disk;
    logic [COUNT_W-1:0]   r_free_cnt,   n_free_cnt;
    t_status              r_status,     n_status;
    logic [IDX_W-1:0]     r_granted,    n_granted;
    logic                 r_out_valid,  n_out_valid;
    t_status              r_out_status, n_out_status;
    logic [IDX_W-1:0]     r_out_grant,  n_out_grant;
    logic [COUNT_W-1:0]   r_out_count,  n_out_count;

    // map RAM
    logic                ram_we;
    logic [RAW-1:0]      ram_waddr;
    logic [ROW_BITS-1:0] ram_wdata;
    logic                ram_re;
    logic [RAW-1:0]      ram_raddr;
    logic [ROW_BITS-1:0] ram_rdata;

    bba_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (ROWS),
        .AW    (RAW)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // derived bounds
    logic [PW-1:0] ds_pw;
    logic [PW-1:0] bound_pw;
    logic [PW-1:0] rsv_pw;
    logic [PW-1:0] fmt_cnt_pw;
    logic [PW-1:0] idx_pw;
    t_cmd          req_cmd;
    logic          accept;

    assign ds_pw      = PW'(r_data_start);
    assign bound_pw   = (PW'(r_disk_blocks) < MAP_PW) ? PW'(r_disk_blocks) : MAP_PW;
    assign rsv_pw     = (ds_pw < MAP_PW) ? ds_pw : MAP_PW;
    assign fmt_cnt_pw = bound_pw - rsv_pw;
    assign idx_pw     = PW'(i_req.block_index);
    assign req_cmd    = t_cmd'(i_req.cmd);
    assign accept     = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);

    // row check: candidates are free bits inside [data_start, disk bound)
    logic [PW-1:0]        chk_pos [ROW_BITS];
    logic [PW-1:0]        sw_pos  [ROW_BITS];
    logic [ROW_BITS-1:0]  cand;
    logic [ROW_BITS-1:0]  sweep_pat;
    logic [ROW_SHIFT-1:0] hit_bit;
    logic                 hit;
    logic [PW-1:0]        next_start;
    logic                 chk_last;
    logic [PW-1:0]        grant_pw;

    always_comb begin
        for (int j = 0; j < ROW_BITS; j++) begin
            chk_pos[j]   = PW'({r_chk_row, ROW_SHIFT'(j)});
            sw_pos[j]    = PW'({r_row[RAW-1:0], ROW_SHIFT'(j)});
            cand[j]      = !ram_rdata[j] && (chk_pos[j] >= ds_pw) && (chk_pos[j] < bound_pw);
            sweep_pat[j] = r_fmt && (sw_pos[j] < ds_pw);
        end
        hit_bit = '0;
        for (int j = ROW_BITS - 1; j >= 0; j--) begin
            if (cand[j]) begin
                hit_bit = ROW_SHIFT'(j);
            end
        end
    end

    assign hit        = |cand;
    assign next_start = (PW'(r_chk_row) + PW'(1)) << ROW_SHIFT;
    assign chk_last   = (next_start >= bound_pw);
    assign grant_pw   = PW'({r_chk_row, hit_bit});

    always_comb begin
        n_state      = r_state;
        n_row        = r_row;
        n_fmt        = r_fmt;
        n_chk_row    = r_chk_row;
        n_chk_vld    = r_chk_vld;
        n_frow       = r_frow;
        n_fbit       = r_fbit;
        n_fin_disk   = r_fin_disk;
        n_free_cnt   = r_free_cnt;
        n_status     = r_status;
        n_granted    = r_granted;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_grant  = r_out_grant;
        n_out_count  = r_out_count;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = '0;
        ram_re       = 1'b0;
        ram_raddr    = '0;

        // drop the result word once taken
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_SWEEP: begin
                ram_we    = 1'b1;
                ram_waddr = r_row[RAW-1:0];
                ram_wdata = sweep_pat;
                if (r_row == LAST_ROW) begin
                    n_state = r_fmt ? S_DONE : S_IDLE;
                end else begin
                    n_row = r_row + RCW'(1);
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_status  = STS_OK;
                    n_granted = '0;
                    unique case (req_cmd)
                        CMD_FORMAT: begin
                            n_fmt      = 1'b1;
                            n_row      = '0;
                            n_free_cnt = (rsv_pw < bound_pw) ? fmt_cnt_pw[COUNT_W-1:0] : '0;
                            n_state    = S_SWEEP;
                        end
                        CMD_ALLOC: begin
                            if (ds_pw >= bound_pw) begin
                                n_status = STS_NO_FREE;
                                n_state  = S_DONE;
                            end else begin
                                n_row     = {1'b0, ds_pw[RAW+ROW_SHIFT-1:ROW_SHIFT]};
                                n_chk_vld = 1'b0;
                                n_state   = S_SCAN;
                            end
                        end
                        CMD_FREE: begin
                            if (idx_pw >= MAP_PW) begin
                                n_status = STS_OUT_OF_RANGE;
                                n_state  = S_DONE;
                            end else begin
                                ram_re     = 1'b1;
                                ram_raddr  = idx_pw[RAW+ROW_SHIFT-1:ROW_SHIFT];
                                n_frow     = idx_pw[RAW+ROW_SHIFT-1:ROW_SHIFT];
                                n_fbit     = i_req.block_index[ROW_SHIFT-1:0];
                                n_fin_disk = (idx_pw < bound_pw);
                                n_state    = S_FREE;
                            end
                        end
                        CMD_QUERY: begin
                            n_state = S_DONE;
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                if (r_chk_vld && hit) begin
                    // claim the lowest free block of this row
                    ram_we    = 1'b1;
                    ram_waddr = r_chk_row;
                    ram_wdata = ram_rdata | (ROW_BITS'(1) << hit_bit);
                    n_granted = grant_pw[IDX_W-1:0];
                    if (r_free_cnt != '0) begin
                        n_free_cnt = r_free_cnt - COUNT_W'(1);
                    end
                    n_state = S_DONE;
                end else if (r_chk_vld && chk_last) begin
                    n_status = STS_NO_FREE;
                    n_state  = S_DONE;
                end else if (r_row < ROWS_CNT) begin
                    // advance: fetch the next row while this one is checked
                    ram_re    = 1'b1;
                    ram_raddr = r_row[RAW-1:0];
                    n_chk_row = r_row[RAW-1:0];
                    n_chk_vld = 1'b1;
                    n_row     = r_row + RCW'(1);
                end
            end
            S_FREE: begin
                if (ram_rdata[r_fbit]) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_frow;
                    ram_wdata = ram_rdata & ~(ROW_BITS'(1) << r_fbit);
                    if (r_fin_disk && (r_free_cnt < COUNT_MAX)) begin
                        n_free_cnt = r_free_cnt + COUNT_W'(1);
                    end
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_grant  = r_granted;
                    n_out_count  = r_free_cnt;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_row       <= '0;
            r_fmt       <= 1'b0;
            r_chk_vld   <= 1'b0;
            r_free_cnt  <= COUNT_MAX;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_fmt       <= n_fmt;
            r_chk_vld   <= n_chk_vld;
            r_free_cnt  <= n_free_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk_row    <= n_chk_row;
        r_frow       <= n_frow;
        r_fbit       <= n_fbit;
        r_fin_disk   <= n_fin_disk;
        r_status     <= n_status;
        r_granted    <= n_granted;
        r_out_status <= n_out_status;
        r_out_grant  <= n_out_grant;
        r_out_count  <= n_out_count;
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.granted_block = r_out_grant;
    assign o_rsp.free_count    = r_out_count;

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !ram_we)
        else $error("map written while idle");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != S_IDLE))
        else $error("command accepted without leaving idle");

    a_grant_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status != STS_OK)) |-> (o_rsp.granted_block == '0))
        else $error("block granted on a failed command");

    a_read_in_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_re |-> (RCW'(ram_raddr) < ROWS_CNT))
        else $error("map read beyond last row");

    a_load_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result word loaded outside completion");

endmodule

`default_nettype wire

>>> test/bba_tb_pkg.sv
`timescale 1ns / 1ps

package bba_tb_pkg;
    import bba_pkg::*;

    localparam int MAP_SIZE = 256;

    typedef struct packed {
        t_status            status;
        logic [IDX_W-1:0]   granted;
        logic [COUNT_W-1:0] free_count;
    } t_reply;

    // Mirror of the block map and free count; predicts the reply word of each command.
    class alloc_tracker;
        bit                 taken [MAP_SIZE];
        logic [DISK_W-1:0]  disk_sz;
        logic [START_W-1:0] first_data;
        logic [COUNT_W-1:0] free_cnt;
        t_reply             replies_due [$];
        int                 errors;

        function new();
            foreach (taken[i]) taken[i] = 1'b0;
            disk_sz    = DISK_BLOCKS_RST;
            first_data = DATA_START_RST;
            free_cnt   = DISK_BLOCKS_RST;
            errors     = 0;
        endfunction

        function void set_reg(t_reg r, logic [APB_DATA_W-1:0] v);
            if (r == REG_DISK_BLOCKS) begin
                disk_sz = v[DISK_W-1:0];
            end else begin
                first_data = v[START_W-1:0];
            end
        endfunction

        // Blocks at or past this index are outside the disk.
        function int search_limit();
            return (int'(disk_sz) < MAP_SIZE) ? int'(disk_sz) : MAP_SIZE;
        endfunction

        function int pending();
            return replies_due.size();
        endfunction

        function logic [IDX_W-1:0] pick_used();
            int hits [$];
            foreach (taken[i]) if (taken[i]) hits.push_back(i);
            if (hits.size() == 0) return IDX_W'($urandom_range(0, MAP_SIZE - 1));
            return IDX_W'(hits[$urandom_range(0, hits.size() - 1)]);
        endfunction

        function void take_command(t_cmd c, logic [IDX_W-1:0] idx);
            t_reply r;
            int     top;
            int     rsv;
            int     k;
            r.status  = STS_OK;
            r.granted = '0;
            top       = search_limit();
            case (c)
                CMD_FORMAT: begin
                    rsv = (int'(first_data) < MAP_SIZE) ? int'(first_data) : MAP_SIZE;
                    foreach (taken[i]) taken[i] = (i < rsv);
                    free_cnt = (rsv < top) ? COUNT_W'(top - rsv) : '0;
                end
                CMD_ALLOC: begin
                    for (k = int'(first_data); k < top; k++) begin
                        if (!taken[k]) break;
                    end
                    if (k < top) begin
                        taken[k]  = 1'b1;
                        r.granted = IDX_W'(k);
                        if (free_cnt != '0) free_cnt = free_cnt - 1'b1;
                    end else begin
                        r.status = STS_NO_FREE;
                    end
                end
                CMD_FREE: begin
                    if (int'(idx) >= MAP_SIZE) begin
                        r.status = STS_OUT_OF_RANGE;
                    end else if (taken[idx]) begin
                        taken[idx] = 1'b0;
                        // blocks past the disk size are released without counting
                        if (int'(idx) < top && free_cnt < COUNT_MAX) free_cnt = free_cnt + 1'b1;
                    end
                end
                default: ;
            endcase
            r.free_count = free_cnt;
            replies_due.push_back(r);
        endfunction

        function void check_reply(logic [STATUS_W-1:0] s, logic [IDX_W-1:0] g,
                                  logic [COUNT_W-1:0] f);
            t_reply want;
            if (replies_due.size() == 0) begin
                errors++;
                $display("%0t: reply word with none due: status %0d granted %0d free %0d",
                         $time, s, g, f);
                return;
            end
            want = replies_due.pop_front();
            if (s !== want.status) begin
                errors++;
                $display("%0t: status expected %0d, actual %0d", $time, want.status, s);
            end
            if (g !== want.granted) begin
                errors++;
                $display("%0t: granted_block expected %0d, actual %0d", $time, want.granted, g);
            end
            if (f !== want.free_count) begin
                errors++;
                $display("%0t: free count expected %0d, actual %0d",
                         $time, want.free_count, f);
            end
        endfunction
    endclass

endpackage

>>> test/tb_block_bitmap_allocator_unit.sv
`timescale 1ns / 1ps

module tb_block_bitmap_allocator_unit;
    import bba_pkg::*;
    import bba_tb_pkg::*;

    localparam int CYCLE_LIMIT  = 500_000;
    localparam int ITEM_TARGET  = 850;
    // longest command is a full-map scan; leave margin
    localparam int DRAIN_CYCLES = 40;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    bba_req_if req_ch ();
    bba_rsp_if rsp_ch ();

    alloc_tracker book;
    bit           quiet;        // phase with no idling on either side
    int           words_sent;
    int           cycle_count = 0;

    block_bitmap_allocator_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop: a hung handshake must not run forever.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic int draw_wait();
        return quiet ? 0 : $urandom_range(0, 7);
    endfunction

    function automatic t_cmd pick_cmd();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) return CMD_ALLOC;
        if (roll < 80) return CMD_FREE;
        if (roll < 92) return CMD_QUERY;
        return CMD_FORMAT;
    endfunction

    // Favour blocks that are in use or inside the disk or up to four past its edge, so frees do real work.
    function automatic logic [IDX_W-1:0] pick_index();
        int roll;
        int near_top;
        roll     = $urandom_range(0, 99);
        near_top = book.search_limit() + 4;
        if (near_top > MAP_SIZE - 1) near_top = MAP_SIZE - 1;
        if (roll < 40) return book.pick_used();
        if (roll < 80) return IDX_W'($urandom_range(0, near_top));
        return IDX_W'($urandom_range(0, MAP_SIZE - 1));
    endfunction

    // Offer one command word after a random gap; hold it until the block takes it.
    task automatic push_word(t_cmd c, logic [IDX_W-1:0] idx);
        int gap;
        gap = draw_wait();
        @(negedge i_clk);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.cmd         <= c;
        req_ch.block_index <= idx;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        book.take_command(c, idx);
        words_sent++;
    endtask

    // Drop valid, wait for every reply word, then let the block go quiet.
    task automatic settle();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (book.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Two-phase register write: setup, then access until pready.
    task automatic apb_write(t_reg r, logic [APB_DATA_W-1:0] v);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        book.set_reg(r, v);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_idle(t_reg r, logic [APB_DATA_W-1:0] v);
        settle();
        apb_write(r, v);
    endtask

    // Reply side: stall a random number of cycles, then take the next word and check it.
    initial begin : reply_sink
        int stall;
        rsp_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = draw_wait();
            if (stall > 0) begin
                @(negedge i_clk);
                rsp_ch.ready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (rsp_ch.valid !== 1'b1);
            book.check_reply(rsp_ch.status, rsp_ch.granted_block, rsp_ch.free_count);
        end
    end

    initial begin : stimulus
        int                 roll;
        int                 hi;
        int                 phase_len;
        logic [DISK_W-1:0]  disk_pick;
        logic [START_W-1:0] start_pick;

        book       = new();
        quiet      = 1'b0;
        words_sent = 0;

        req_ch.valid       = 1'b0;
        req_ch.cmd         = CMD_QUERY;
        req_ch.block_index = '0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;

        // hold reset from time zero; the block then runs its clearing pass on its own
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed: reset state, map clear, 256 free, data from block 8 ---
        push_word(CMD_QUERY,  8'hFF);     // index ignored outside a free
        push_word(CMD_ALLOC,  8'h00);     // lowest data block, 8
        push_word(CMD_FREE,   8'd8);
        push_word(CMD_FREE,   8'd0);      // already free: ok, no change
        push_word(CMD_FORMAT, 8'hA5);     // reserve 0..7, count 248
        push_word(CMD_ALLOC,  8'h00);
        push_word(CMD_ALLOC,  8'h00);
        push_word(CMD_FREE,   8'd3);      // metadata block released and counted
        push_word(CMD_ALLOC,  8'h00);     // search still starts at data start
        push_word(CMD_FREE,   8'd255);    // top of the map, already free

        // one-block disk with no metadata: search from block 0
        write_idle(REG_DISK_BLOCKS, 32'd1);
        write_idle(REG_DATA_START,  32'd0);
        push_word(CMD_FORMAT, 8'h00);
        push_word(CMD_ALLOC,  8'h00);
        push_word(CMD_ALLOC,  8'h00);     // disk full
        // grow the disk without a format: count stays at zero on the next grant
        write_idle(REG_DISK_BLOCKS, 32'd2);
        push_word(CMD_ALLOC,  8'h00);

        // disk size past the map, data start at the top
        write_idle(REG_DISK_BLOCKS, 32'd511);
        write_idle(REG_DATA_START,  32'd255);
        push_word(CMD_FORMAT, 8'h00);
        push_word(CMD_ALLOC,  8'h00);
        push_word(CMD_ALLOC,  8'h00);
        // shrink the disk: release outside it is not counted, inside it is
        write_idle(REG_DISK_BLOCKS, 32'd100);
        push_word(CMD_FREE,   8'd200);
        push_word(CMD_FREE,   8'd50);

        // empty disk: data start above it, nothing to hand out
        write_idle(REG_DISK_BLOCKS, 32'd0);
        push_word(CMD_ALLOC,  8'h00);
        push_word(CMD_FORMAT, 8'h00);

        // full disk, no metadata
        write_idle(REG_DISK_BLOCKS, 32'd256);
        write_idle(REG_DATA_START,  32'd0);
        push_word(CMD_FORMAT, 8'h00);
        push_word(CMD_ALLOC,  8'h00);
        push_word(CMD_FREE,   8'd0);

        // --- random phases: new sizes, mostly a format first, then a command mix ---
        while (words_sent < ITEM_TARGET) begin
            settle();
            quiet = ($urandom_range(0, 3) == 0);

            // small disks fill quickly, so those phases often run into the full case
            roll = $urandom_range(0, 99);
            if (roll < 35)      disk_pick = DISK_W'($urandom_range(1, 24));
            else if (roll < 60) disk_pick = DISK_W'($urandom_range(25, 96));
            else if (roll < 75) disk_pick = DISK_W'(256);
            else if (roll < 82) disk_pick = '0;
            else if (roll < 90) disk_pick = DISK_W'($urandom_range(257, 511));
            else                disk_pick = DISK_W'($urandom_range(1, 256));

            hi = (disk_pick == '0) ? 0 : int'(disk_pick) - 1;
            if (hi > 255) hi = 255;
            roll = $urandom_range(0, 99);
            if (roll < 35)      start_pick = START_W'($urandom_range(0, 4));
            else if (roll < 70) start_pick = START_W'($urandom_range(0, hi));
            else if (roll < 80) start_pick = 8'd255;
            else                start_pick = START_W'($urandom_range(0, 255));

            // sometimes change only one register, leaving the count stale
            roll = $urandom_range(0, 5);
            if (roll != 1) apb_write(REG_DISK_BLOCKS, APB_DATA_W'(disk_pick));
            if (roll != 0) apb_write(REG_DATA_START,  APB_DATA_W'(start_pick));

            if ($urandom_range(0, 4) != 0) push_word(CMD_FORMAT, IDX_W'($urandom_range(0, 255)));

            phase_len = $urandom_range(15, 70);
            repeat (phase_len) push_word(pick_cmd(), pick_index());
        end

        settle();
        if (book.errors == 0 && book.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
